// ===== hdl/dqvs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqvs_pkg
// Shared types, constants and helpers of the deque with value search.
// ----------------------------------------------------------------------------
`default_nettype none

package dqvs_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int OP_BITS   = 3;
	localparam int STAT_BITS = 2;

	localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_BITS-1:0] OP_CONTAINS   = 3'd4;
	localparam logic [OP_BITS-1:0] OP_REMOVE     = 3'd5;

	localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd3;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		idx_t  raddr;
	} mem_req_t;

	typedef struct packed {
		word_t                 front_word;
		word_t                 back_word;
		logic                  found;
		cnt_t                  entry_count;
		logic [STAT_BITS-1:0]  status;
	} result_t;

	// Store position of the entry at a given offset from the front.
	function automatic idx_t slot(input idx_t head, input idx_t offset);
		slot = head + offset;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/dqvs_req_if.sv =====
// ----------------------------------------------------------------------------
// dqvs_req_if
// Request channel: one op and one data word per word moved.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqvs_req_if import dqvs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_BITS-1:0]  op;
	word_t               data_word;

	modport source (output valid, output op, output data_word, input ready);
	modport sink   (input valid, input op, input data_word, output ready);
endinterface

`default_nettype wire

// ===== hdl/dqvs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dqvs_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqvs_rsp_if import dqvs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	word_t                 front_word;
	word_t                 back_word;
	logic                  found;
	cnt_t                  entry_count;
	logic [STAT_BITS-1:0]  status;

	modport source (output valid, output front_word, output back_word, output found,
		output entry_count, output status, input ready);
	modport sink   (input valid, input front_word, input back_word, input found,
		input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/dqvs_store.sv =====
// ----------------------------------------------------------------------------
// dqvs_store
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dqvs_store import dqvs_pkg::*; (
	input  wire      clk,
	input  mem_req_t req,
	output word_t    rdata
);

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/dqvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqvs_ctrl
// Sequencer of the deque: runs each op over the entry store, one read and
// one compare or one move per cycle, then fetches the front and back words.
// ----------------------------------------------------------------------------
`default_nettype none

module dqvs_ctrl import dqvs_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire [OP_BITS-1:0]   in_op,
	input  word_t               in_data,
	output logic                res_valid,
	input  wire                 res_ready,
	output result_t             res,
	output mem_req_t            mem_req,
	input  word_t               mem_rdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_READF = 3'd4;
	localparam logic [2:0] S_READB = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]           state_q;
	logic [OP_BITS-1:0]   op_q;
	word_t                val_q;
	idx_t                 head_q;
	cnt_t                 count_q;
	cnt_t                 rd_i_q;
	logic                 cmp_v_q;
	cnt_t                 cmp_i_q;
	logic                 wr_v_q;
	idx_t                 wr_i_q;
	logic                 found_q;
	logic [STAT_BITS-1:0] status_q;
	word_t                front_q;

	logic  full, empty, issue, hit, last_cmp, accept;
	cnt_t  count_m1;

	assign full     = (count_q >= CNT_BITS'(DEPTH));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - CNT_BITS'(1);
	assign issue    = (rd_i_q < count_q);
	assign hit      = cmp_v_q && (mem_rdata == val_q);
	assign last_cmp = cmp_v_q && (cmp_i_q == count_m1);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = slot(head_q, wr_i_q);
		mem_req.wdata = mem_rdata;
		mem_req.raddr = slot(head_q, count_m1[IDX_BITS-1:0]);
		unique case (state_q)
			S_EXEC: begin
				if (op_q == OP_PUSH_FRONT && !full) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = head_q - IDX_BITS'(1);
					mem_req.wdata = val_q;
				end else if (op_q == OP_PUSH_BACK && !full) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = slot(head_q, count_q[IDX_BITS-1:0]);
					mem_req.wdata = val_q;
				end
			end
			S_SCAN, S_SHIFT: begin
				mem_req.raddr = slot(head_q, rd_i_q[IDX_BITS-1:0]);
				mem_req.we    = (state_q == S_SHIFT) && wr_v_q;
			end
			S_READF: mem_req.raddr = head_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			cmp_v_q  <= 1'b0;
			wr_v_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= in_op;
						val_q    <= in_data;
						found_q  <= 1'b0;
						status_q <= ST_OK;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_READF;
					case (op_q)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CNT_BITS'(1);
								if (op_q == OP_PUSH_FRONT) begin
									head_q <= head_q - IDX_BITS'(1);
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								count_q <= count_m1;
								if (op_q == OP_POP_FRONT) begin
									head_q <= head_q + IDX_BITS'(1);
								end
							end
						end
						OP_CONTAINS, OP_REMOVE: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								rd_i_q  <= '0;
								cmp_v_q <= 1'b0;
								state_q <= S_SCAN;
							end
						end
						default: ;
					endcase
				end
				S_SCAN: begin
					// Reads run one entry ahead of the compare.
					if (hit) begin
						found_q <= 1'b1;
						cmp_v_q <= 1'b0;
						if (op_q == OP_REMOVE) begin
							rd_i_q  <= cmp_i_q + CNT_BITS'(1);
							wr_v_q  <= 1'b0;
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_READF;
						end
					end else if (last_cmp) begin
						cmp_v_q  <= 1'b0;
						status_q <= (op_q == OP_REMOVE) ? ST_NOT_FOUND : ST_OK;
						state_q  <= S_READF;
					end else begin
						cmp_v_q <= issue;
						cmp_i_q <= rd_i_q;
						if (issue) begin
							rd_i_q <= rd_i_q + CNT_BITS'(1);
						end
					end
				end
				S_SHIFT: begin
					// Each entry behind the match moves one place towards the front.
					wr_v_q <= issue;
					wr_i_q <= rd_i_q[IDX_BITS-1:0] - IDX_BITS'(1);
					if (issue) begin
						rd_i_q <= rd_i_q + CNT_BITS'(1);
					end else if (!wr_v_q) begin
						count_q <= count_m1;
						state_q <= S_READF;
					end
				end
				S_READF: state_q <= S_READB;
				S_READB: begin
					front_q <= mem_rdata;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid       = (state_q == S_FIN);
	assign res.front_word  = empty ? word_t'(0) : front_q;
	assign res.back_word   = empty ? word_t'(0) : mem_rdata;
	assign res.found       = found_q;
	assign res.entry_count = count_q;
	assign res.status      = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("entry count above store depth");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted word did not start execution");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (state_q == S_EXEC || state_q == S_SHIFT))
		else $error("store written outside push or shift");

	a_found_ops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.found |-> (op_q == OP_CONTAINS || op_q == OP_REMOVE))
		else $error("found flag set for an op without search");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(count_q))
		else $error("entry count changed while idle");

endmodule

`default_nettype wire

// ===== hdl/deque_with_value_search_core.sv =====
// ----------------------------------------------------------------------------
// deque_with_value_search_core
// Bounded double-ended queue of signed words with search and remove by value.
// ----------------------------------------------------------------------------
// Pushes, pops and unused ops skip the value scan. Contains and remove scan the
// entries through the single store read port, which remove also uses to close
// the gap behind the match. One word is in work at a time; the next is taken in
// the cycle after the result moves to the output register.
// Reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_value_search_core import dqvs_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	dqvs_req_if.sink    req,
	dqvs_rsp_if.source  rsp
);

	mem_req_t mem_req;
	word_t    mem_rdata;
	logic     res_valid, res_ready;
	result_t  res;
	logic     out_valid_q;
	result_t  out_q;

	dqvs_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	dqvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.op),
		.in_data   (req.data_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// The output register frees the sequencer as soon as it holds the result.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.front_word  = out_q.front_word;
	assign rsp.back_word   = out_q.back_word;
	assign rsp.found       = out_q.found;
	assign rsp.entry_count = out_q.entry_count;
	assign rsp.status      = out_q.status;

endmodule

`default_nettype wire
